// ===== sv/tfpc_pkg.sv =====
package tfpc_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TEMP  = 2'd0;
    localparam t_kind KIND_PIXEL = 2'd1;
    localparam t_kind KIND_PEC   = 2'd2;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_DEV_ADDR = 2'd0;
    localparam t_cfg_index CFG_READ_CMD = 2'd1;

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] DEV_ADDR_INIT = 8'd20;
    localparam logic [7:0] READ_CMD_INIT = 8'd76;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  pixel_index;
        logic [15:0] value;
        logic        pec_ok;
        logic        frame_end;
    } t_result;

    // one byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] x);
        logic [7:0] v;
        v = x;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // CRC over write address, command, read address
    function automatic logic [7:0] crc8_seed(input logic [7:0] dev, input logic [7:0] cmd);
        logic [7:0] c;
        c = crc8_byte(dev);
        c = crc8_byte(cmd ^ c);
        c = crc8_byte((dev + 8'd1) ^ c);
        return c;
    endfunction

endpackage

// ===== sv/thermal_frame_pec_checker.sv =====
// Thermal sensor frame checker with SMBus-style CRC-8 PEC.
// Slave stream: one frame byte per word; tuser flags the first byte of a frame.
// A frame is chip temperature (2 bytes, little endian), PIXEL_COUNT pixel words
// (2 bytes each) and one PEC byte. The CRC is seeded from write address,
// command and read address at each frame start.
// Master stream: one word per completed 16-bit value, and one per PEC byte with
// the pass/fail flag and tlast set. Low bytes, and bytes outside a frame, give
// no word.
// The byte is caught in the input register when accepted, and the result register
// loads from it. Throughput: one byte per cycle while the master side is not
// stalled, set by the combinational CRC byte update between the two registers.
// Configuration: plain write port, index 0 write address, index 1 command;
// write only while the block is idle.
// Reset: counter, CRC and frame state cleared, registers back to 20 and 76,
// both stream sides empty.
// Stall: a result holds on the master side until taken; one more byte waits
// in the input register, after which s_axis_tready drops.
module thermal_frame_pec_checker
    import tfpc_pkg::*;
#(
    parameter int PIXEL_COUNT = 16
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] pixel_index, [19:4] word_value, [20] pec_ok
    output logic [1:0]  m_axis_tuser,   // [1:0] word_kind
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic       r_out_valid;
    t_result    r_out;

    logic       out_can_load;
    logic       advance;
    logic [7:0] seed;
    logic       res_valid;
    t_result    res;

    assign out_can_load  = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_can_load;
    assign s_axis_tready = !r_in_valid || out_can_load;

    tfpc_seed u_seed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_seed     (seed)
    );

    tfpc_frame #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_seed      (seed),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_can_load) begin
                r_out_valid <= advance && res_valid;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.pec_ok, r_out.value, r_out.pixel_index};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.frame_end;

endmodule

// ===== sv/tfpc_seed.sv =====
module tfpc_seed
    import tfpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg_index i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    output logic [7:0] o_seed
);

    localparam logic [7:0] SEED_INIT = crc8_seed(DEV_ADDR_INIT, READ_CMD_INIT);

    logic [7:0] r_dev_addr;
    logic [7:0] r_read_cmd;
    logic [7:0] r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_INIT;
            r_read_cmd <= READ_CMD_INIT;
            r_seed     <= SEED_INIT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEV_ADDR: r_dev_addr <= i_cfg_data;
                    CFG_READ_CMD: r_read_cmd <= i_cfg_data;
                    default: ;
                endcase
            end
            // preamble CRC is registered from the config registers and follows them in the next cycle
            r_seed <= crc8_seed(r_dev_addr, r_read_cmd);
        end
    end

    assign o_seed = r_seed;

endmodule

// ===== sv/tfpc_frame.sv =====
module tfpc_frame
    import tfpc_pkg::*;
#(
    parameter int PIXEL_COUNT = 16
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic [7:0] i_seed,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int PEC_POS = 2 + 2 * PIXEL_COUNT;
    localparam int POS_NAT = $clog2(PEC_POS + 1);
    localparam int POS_W   = (POS_NAT < 5) ? 5 : POS_NAT;
    localparam logic [POS_W-1:0] PEC_POS_V = POS_W'(PEC_POS);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_low, n_low;
    logic [7:0]       r_crc, n_crc;
    logic             r_active, n_active;

    logic             eff_active;
    logic [POS_W-1:0] eff_pos;
    logic [7:0]       eff_crc;
    logic [POS_W-1:0] pix_off;

    always_comb begin
        eff_active  = i_start | r_active;
        eff_pos     = i_start ? '0 : r_pos;
        eff_crc     = i_start ? i_seed : r_crc;
        pix_off     = eff_pos - POS_W'(3);
        n_pos       = r_pos;
        n_low       = r_low;
        n_crc       = r_crc;
        n_active    = r_active;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (eff_active) begin
            if (eff_pos >= PEC_POS_V) begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_PEC;
                o_res.pec_ok    = (eff_crc == i_byte);
                o_res.frame_end = 1'b1;
                n_crc           = eff_crc;
                n_pos           = '0;
                n_active        = 1'b0;
            end else begin
                n_crc    = crc8_byte(i_byte ^ eff_crc);
                n_pos    = eff_pos + POS_W'(1);
                n_active = 1'b1;
                if (!eff_pos[0]) begin
                    n_low = i_byte;
                end else begin
                    o_res_valid = 1'b1;
                    o_res.value = {i_byte, r_low};
                    if (eff_pos == POS_W'(1)) begin
                        o_res.kind = KIND_TEMP;
                    end else begin
                        o_res.kind        = KIND_PIXEL;
                        o_res.pixel_index = pix_off[4:1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_low    <= '0;
            r_crc    <= '0;
            r_active <= 1'b0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_low    <= n_low;
            r_crc    <= n_crc;
            r_active <= n_active;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
    import tfpc_pkg::*;
();

    localparam int PIXELS      = 16;
    localparam int PEC_POS     = 2 + 2 * PIXELS;
    localparam int PHASE_BYTES = 325;

    localparam t_cfg_index CFG_SPARE = 2'd3;   // no register behind it

    typedef enum {FR_GOOD, FR_BAD_PEC, FR_BAD_DATA, FR_SHORT} t_frame_shape;

    // Tracks the frame state on its own and queues the words the block owes us.
    class t_frame_word_tracker;
        logic [7:0] dev_addr;
        logic [7:0] read_cmd;
        int unsigned byte_pos;
        logic [7:0] low_hold;
        logic [7:0] crc;
        bit         in_frame;
        int         errors;
        t_result    pending_words[$];

        function new();
            dev_addr = DEV_ADDR_INIT;
            read_cmd = READ_CMD_INIT;
            byte_pos = 0;
            low_hold = '0;
            crc      = '0;
            in_frame = 1'b0;
            errors   = 0;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] x);
            logic [7:0] v;
            v = x;
            repeat (8) v = {v[6:0], 1'b0} ^ (v[7] ? CRC_POLY : 8'h00);
            return v;
        endfunction

        // write address, command, read address (address + 1 wraps at 8 bits)
        function logic [7:0] frame_seed();
            logic [7:0] c;
            logic [7:0] rd_addr;
            rd_addr = dev_addr + 8'd1;
            c = crc_step(dev_addr);
            c = crc_step(read_cmd ^ c);
            c = crc_step(rd_addr ^ c);
            return c;
        endfunction

        function void write_cfg(t_cfg_index idx, logic [7:0] v);
            case (idx)
                CFG_DEV_ADDR: dev_addr = v;
                CFG_READ_CMD: read_cmd = v;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            t_result r;
            int unsigned p;
            int unsigned idx;
            if (first) begin
                crc      = frame_seed();
                byte_pos = 0;
                in_frame = 1'b1;
            end
            if (!in_frame) return;
            p = byte_pos;
            if (p >= PEC_POS) begin
                r.kind        = KIND_PEC;
                r.pixel_index = '0;
                r.value       = '0;
                r.pec_ok      = (crc == b);
                r.frame_end   = 1'b1;
                pending_words.push_back(r);
                in_frame = 1'b0;
                byte_pos = 0;
                return;
            end
            crc      = crc_step(b ^ crc);
            byte_pos = p + 1;
            if (p[0] == 1'b0) begin
                low_hold = b;
                return;
            end
            idx = (p - 3) >> 1;
            r.kind        = (p == 1) ? KIND_TEMP : KIND_PIXEL;
            r.pixel_index = (p == 1) ? 4'd0 : idx[3:0];
            r.value       = {b, low_hold};
            r.pec_ok      = 1'b0;
            r.frame_end   = 1'b0;
            pending_words.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [1:0] kind, logic [23:0] data, logic last);
            t_result want;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word kind=%0d data=%h last=%b",
                                 kind, data, last));
                return;
            end
            want = pending_words.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %0d", kind, want.kind));
            if (data[3:0] !== want.pixel_index)
                report($sformatf("pixel index %0d, want %0d", data[3:0], want.pixel_index));
            if (data[19:4] !== want.value)
                report($sformatf("value %h, want %h", data[19:4], want.value));
            if (data[20] !== want.pec_ok)
                report($sformatf("pec_ok %b, want %b", data[20], want.pec_ok));
            if (last !== want.frame_end)
                report($sformatf("tlast %b, want %b", last, want.frame_end));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_addr;
    logic [7:0]  i_cfg_data;

    t_frame_word_tracker sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int frame_bytes;

    thermal_frame_pec_checker #(.PIXEL_COUNT(PIXELS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[thermal_frame_pec_checker] ERROR");
        $finish;
    end

    // receiver: checks taken words, then picks tready for the next edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task push_byte(input logic [7:0] b, input logic first);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, first);
    endtask

    task write_reg(input t_cfg_index idx, input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_cfg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every owed word, then let the pipe empty
    task settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task send_frame(input t_frame_shape shape);
        logic [7:0]  fb [0:PEC_POS];
        logic [7:0]  c;
        logic [15:0] w;
        int          n;
        int          k;
        for (k = 0; k <= PIXELS; k++) begin
            case ($urandom_range(15))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                2: w = 16'h8000;
                3: w = 16'h7FFF;
                default: w = 16'($urandom);
            endcase
            fb[2 * k]     = w[7:0];
            fb[2 * k + 1] = w[15:8];
        end
        c = sb.frame_seed();
        for (k = 0; k < PEC_POS; k++) c = t_frame_word_tracker::crc_step(fb[k] ^ c);
        fb[PEC_POS] = c;
        n = PEC_POS + 1;
        case (shape)
            FR_BAD_PEC:  fb[PEC_POS] ^= 8'h01 << $urandom_range(7);
            FR_BAD_DATA: begin
                k = $urandom_range(PEC_POS - 1);
                fb[k] ^= 8'h01 << $urandom_range(7);
            end
            FR_SHORT:    n = $urandom_range(PEC_POS, 1);
            default: ;
        endcase
        for (k = 0; k < n; k++) push_byte(fb[k], k == 0);
        frame_bytes += n;
    endtask

    initial begin
        int  ph;
        int  r;
        bit  pressure_done;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_DEV_ADDR;
        i_cfg_data    <= '0;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray bytes outside a frame are dropped
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // restart in the middle of a word abandons the old frame
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b1);

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                1: begin
                    write_reg(CFG_DEV_ADDR, 8'hFF);   // read address wraps to 0
                    write_reg(CFG_READ_CMD, 8'h00);
                end
                2: begin
                    write_reg(CFG_DEV_ADDR, 8'h00);
                    write_reg(CFG_READ_CMD, 8'hFF);
                end
                3: begin
                    write_reg(CFG_DEV_ADDR, 8'hFE);
                    write_reg(CFG_READ_CMD, 8'($urandom));
                end
                4: begin
                    write_reg(CFG_SPARE, 8'($urandom));
                    write_reg(CFG_DEV_ADDR, 8'($urandom));
                    write_reg(CFG_READ_CMD, 8'($urandom));
                end
                5: begin
                    write_reg(CFG_READ_CMD, 8'($urandom));
                    write_reg(CFG_DEV_ADDR, 8'($urandom_range(254)));
                end
                default: ;
            endcase
            case (ph)
                1: begin tx_idle_pct = 64; rx_stall_pct = 0; end
                2: begin tx_idle_pct = 0; rx_stall_pct = 64; end
                3: begin tx_idle_pct = 13; rx_stall_pct = 13; end
                5: begin tx_idle_pct = 13; rx_stall_pct = 13; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase

            frame_bytes   = 0;
            pressure_done = 1'b0;
            send_frame(FR_GOOD);
            while (frame_bytes < PHASE_BYTES) begin
                if (!pressure_done && frame_bytes > 120) begin
                    pressure_done = 1'b1;
                    if (ph == 4) hold_left = 300;    // back up the output side
                    if (ph == 5) settle();           // sender waits for every word
                end
                r = $urandom_range(99);
                if (r < 62)      send_frame(FR_GOOD);
                else if (r < 72) send_frame(FR_BAD_PEC);
                else if (r < 80) send_frame(FR_BAD_DATA);
                else if (r < 90) send_frame(FR_SHORT);
                else begin
                    repeat ($urandom_range(4, 1)) push_byte(8'($urandom), 1'b0);
                end
            end
        end

        settle();
        if (sb.pending_words.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));
        if (sb.errors == 0) begin
            $display("[thermal_frame_pec_checker] OK");
        end else begin
            $display("[thermal_frame_pec_checker] ERROR");
        end
        $finish;
    end

endmodule
